### rtl/ialu_pkg.sv
// Shared constants and opcodes for the multicycle integer ALU.
// No dependencies.
package ialu_pkg;

  localparam int unsigned DATA_WIDTH_DEFAULT = 32;
  localparam int unsigned MUL_DIGIT          = 16;
  localparam int unsigned OPCODE_WIDTH       = 3;

  localparam logic [OPCODE_WIDTH-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_POW = 3'd3;
  localparam logic [OPCODE_WIDTH-1:0] OP_DIV = 3'd4;

endpackage

### rtl/integer_alu_add_sub_mul_pow_div_unit.sv
// Multicycle integer ALU top level: sequencer, output register.
// Depends on ialu_pkg, ialu_mul, ialu_div.
//
// Usage: one beat on the s_axis side carries the opcode in tuser and the two
// operands in tdata; one beat on the m_axis side returns value and remainder in
// tdata and the divide-by-zero flag in tuser. Add, subtract, unsupported
// opcodes and divide by zero go from accept straight to the done state.
// Multiply uses the shared multiplier, which works through the operand in
// digits of up to 16 bits. Power runs square-and-multiply on that multiplier,
// up to two products per exponent bit. Divide runs the restoring divider,
// one quotient bit per cycle.
// One item is in work at a time; s_axis_tready is high only while idle.
// A finished result waits in the output register; a new item may be taken
// meanwhile, and its result is held back until the register is free.
// Reset clears the sequencer and drops m_axis_tvalid; the data registers are not reset.
module integer_alu_add_sub_mul_pow_div_unit #(
  parameter int unsigned DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // operand_a, operand_b, zero pad
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // opcode
  input  logic [ialu_pkg::OPCODE_WIDTH-1:0]     s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // value, remainder, zero pad
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // divide_by_zero
  output logic                                  m_axis_tuser
);
  import ialu_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned TdW  = ((2*DATA_WIDTH+7)/8)*8;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_POW     = 3'd2;
  localparam logic [2:0] S_POW_ACC = 3'd3;
  localparam logic [2:0] S_POW_SQ  = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]   state_q, state_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] sq_q, sq_d;
  logic [W-1:0] exp_q, exp_d;
  logic [W-1:0] res_val_q, res_val_d;
  logic [W-1:0] res_rem_q, res_rem_d;
  logic         res_dbz_q, res_dbz_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_val_q, out_rem_q;
  logic         out_dbz_q;
  logic         load_out;

  logic [W-1:0] in_a, in_b;
  logic [OPCODE_WIDTH-1:0] in_op;
  logic         accept;

  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic         div_start, div_done;
  logic [W-1:0] div_quo, div_rem;

  assign in_a   = s_axis_tdata[W-1:0];
  assign in_b   = s_axis_tdata[2*W-1:W];
  assign in_op  = s_axis_tuser;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  ialu_mul #(.DataWidth(W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .product_o(mul_p)
  );

  ialu_div #(.DataWidth(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_a),
    .divisor_i  (in_b),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    exp_d     = exp_q;
    res_val_d = res_val_q;
    res_rem_d = res_rem_q;
    res_dbz_d = res_dbz_q;
    mul_start = 1'b0;
    mul_a     = in_a;
    mul_b     = in_b;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_val_d = '0;
          res_rem_d = '0;
          res_dbz_d = 1'b0;
          state_d   = S_DONE;
          unique case (in_op)
            OP_ADD: res_val_d = in_a + in_b;
            OP_SUB: res_val_d = in_a - in_b;
            OP_MUL: begin
              mul_start = 1'b1;
              state_d   = S_MUL;
            end
            OP_POW: begin
              acc_d   = W'(1);
              sq_d    = in_a;
              exp_d   = in_b;
              state_d = S_POW;
            end
            OP_DIV: begin
              if (in_b == '0) begin
                res_dbz_d = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          res_val_d = mul_p;
          state_d   = S_DONE;
        end
      end
      S_POW: begin
        if (exp_q == '0) begin
          res_val_d = acc_q;
          state_d   = S_DONE;
        end else if (exp_q[0]) begin
          mul_a     = acc_q;
          mul_b     = sq_q;
          mul_start = 1'b1;
          state_d   = S_POW_ACC;
        end else begin
          mul_a     = sq_q;
          mul_b     = sq_q;
          mul_start = 1'b1;
          exp_d     = exp_q >> 1;
          state_d   = S_POW_SQ;
        end
      end
      S_POW_ACC: begin
        if (mul_done) begin
          acc_d    = mul_p;
          exp_d[0] = 1'b0;
          state_d  = S_POW;
        end
      end
      S_POW_SQ: begin
        if (mul_done) begin
          sq_d    = mul_p;
          state_d = S_POW;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_val_d = div_quo;
          res_rem_d = div_rem;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    sq_q      <= sq_d;
    exp_q     <= exp_d;
    res_val_q <= res_val_d;
    res_rem_q <= res_rem_d;
    res_dbz_q <= res_dbz_d;
    if (load_out) begin
      out_val_q <= res_val_q;
      out_rem_q <= res_rem_q;
      out_dbz_q <= res_dbz_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdW'({out_rem_q, out_val_q});
  assign m_axis_tuser  = out_dbz_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("ready after accept");
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("divide by zero with nonzero result");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q || m_axis_tready) else $error("pending result overwritten");

endmodule

### rtl/ialu_mul.sv
// Iterative multiplier, low DATA_WIDTH bits of the product, one digit per cycle.
// Depends on ialu_pkg.
module ialu_mul #(
  parameter int unsigned DataWidth = ialu_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] mcand_i,
  input  logic [DataWidth-1:0] mplier_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] product_o
);
  import ialu_pkg::*;

  localparam int unsigned Dig = (DataWidth < MUL_DIGIT) ? DataWidth : MUL_DIGIT;

  logic                   busy_q, busy_d;
  logic [DataWidth-1:0]   mcand_q, mcand_d;
  logic [DataWidth-1:0]   mplier_q, mplier_d;
  logic [DataWidth-1:0]   acc_q, acc_d;
  logic [DataWidth+Dig-1:0] partial;

  assign partial   = mcand_q * mplier_q[Dig-1:0];
  assign done_o    = busy_q && (mplier_q == '0);
  assign product_o = acc_q;

  always_comb begin
    busy_d   = busy_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      acc_d    = '0;
    end else if (busy_q) begin
      if (mplier_q == '0) begin
        busy_d = 1'b0;
      end else begin
        acc_d    = acc_q + partial[DataWidth-1:0];
        mcand_d  = mcand_q << Dig;
        mplier_d = mplier_q >> Dig;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !start_i |=> !busy_q) else $error("multiplier busy after done");

endmodule

### rtl/ialu_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ialu_pkg.
module ialu_div #(
  parameter int unsigned DataWidth = ialu_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] quotient_o,
  output logic [DataWidth-1:0] remainder_o
);
  import ialu_pkg::*;

  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] div_q, div_d;
  logic [DataWidth:0]   trial, diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DataWidth-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  assign done_o      = busy_q && (cnt_q == '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataWidth);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        rem_d = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
        quo_d = {quo_q[DataWidth-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("divider started with zero divisor");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_q < div_q) else $error("remainder not below divisor");

endmodule
